FILE: sv/cpts_pkg.sv
// Package: request codes, task states, sequencer states and word types.
package cpts_pkg;

    localparam int unsigned TID_W = 3;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_ADMIT    = 3'd1,
        REQ_YIELD    = 3'd2,
        REQ_SLEEP    = 3'd3,
        REQ_EXIT     = 3'd4,
        REQ_BLOCK    = 3'd5,
        REQ_UNBLOCK  = 3'd6,
        REQ_DISPATCH = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        TS_FREE     = 3'd0,
        TS_READY    = 3'd1,
        TS_RUNNING  = 3'd2,
        TS_SLEEPING = 3'd3,
        TS_BLOCKED  = 3'd4,
        TS_EXITED   = 3'd5
    } t_tstate;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOCUR  = 2'd1;
    localparam logic [1:0] STAT_BADTSK = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINS,     // walk sleep list for insert position
        S_SSHIFT,   // shift sleep list right one entry a cycle
        S_WAKE,     // check head sleeper deadline
        S_WSHIFT,   // shift sleep list left after wake
        S_SCAN,     // credit search over ready queue
        S_RSHIFT,   // close gap in ready queue
        S_PICK,     // update credit, make current
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  task_id;
        logic [3:0]  priority_req;
        logic [19:0] sleep_time;
    } t_in_word;

    typedef struct packed {
        logic [2:0] running_task;
        logic       running_valid;
        logic [1:0] status;
    } t_out_word;

endpackage

FILE: sv/credit_priority_task_scheduler.sv
// Top level: sequenced credit-priority task scheduler.
//
// A request is taken when start is high and busy is low; its result word
// appears on o_result with o_done high for exactly one cycle and must be
// taken then, since the receiver cannot stall. Tick, admit and unblock go
// from idle straight to the done state and report from there. Requests that
// run a scheduling pass walk the sleep list and the ready queue one entry a
// cycle through one shared compare unit. A sleep insert walks the sleep list
// to its position, then shifts the later sleepers right and writes the task
// in. Every woken sleeper joins the ready queue and the sleep list shifts
// left behind it. The credit scan visits each ready task, and closing the
// gap moves every task behind the chosen one up. The pass ends with the
// final head check, the credit update and the report (no credit update when
// the pass ends idle). busy drops as the result word appears.
module credit_priority_task_scheduler #(
    parameter int unsigned NUM_TASKS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  cpts_pkg::t_in_word  i_item,
    output logic                busy,
    output logic                o_done,
    output cpts_pkg::t_out_word o_result
);
    import cpts_pkg::*;

    localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int unsigned CW = $clog2(NUM_TASKS + 1);

    // Task tables
    t_tstate        r_tstat [NUM_TASKS];
    logic [3:0]     r_credit[NUM_TASKS];
    logic [3:0]     r_prio  [NUM_TASKS];
    logic [31:0]    r_dl    [NUM_TASKS];
    logic [IW-1:0]  r_rq    [NUM_TASKS];
    logic [IW-1:0]  r_sq    [NUM_TASKS];
    logic [CW-1:0]  r_rcnt, r_scnt;
    logic [31:0]    r_time;
    logic [IW-1:0]  r_cur;
    logic           r_cur_v;

    t_state         r_state, n_state;
    logic [1:0]     r_stat;
    logic [CW-1:0]  r_i;        // walk index
    logic [CW-1:0]  r_best;
    logic [IW-1:0]  r_tsk;      // task under insert, wake or pick
    t_out_word      r_out;
    logic           r_done;

    logic [IW-1:0]  in_id;
    logic           id_ok;
    logic [31:0]    dl_sum;
    logic [32:0]    dl_wide;

    assign id_ok  = (32'(i_item.task_id) < NUM_TASKS);
    assign in_id  = IW'(i_item.task_id);
    assign dl_wide = {1'b0, r_time} + 33'(i_item.sleep_time);
    assign dl_sum  = dl_wide[32] ? 32'hFFFF_FFFF : dl_wide[31:0];

    // Shared compare unit operands
    logic [31:0] cmp_a, cmp_b;
    logic        cmp_lt, cmp_le;
    logic [IW-1:0] s_at_i, r_at_i, r_at_best, s_head;
    assign s_at_i    = r_sq[IW'(r_i)];
    assign r_at_i    = r_rq[IW'(r_i)];
    assign r_at_best = r_rq[IW'(r_best)];
    assign s_head    = r_sq[0];

    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (r_state)
            S_SINS: begin
                cmp_a = r_dl[s_at_i];
                cmp_b = r_dl[r_tsk];
            end
            S_WAKE: begin
                cmp_a = r_dl[s_head];
                cmp_b = r_time;
            end
            S_SCAN: begin
                cmp_a = 32'(r_credit[r_at_best]);
                cmp_b = 32'(r_credit[r_at_i]);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;
    assign cmp_le = cmp_a <= cmp_b;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) begin
                case (t_req'(i_item.req_type))
                    REQ_TICK, REQ_ADMIT, REQ_UNBLOCK: n_state = S_DONE;
                    REQ_DISPATCH: n_state = S_WAKE;
                    REQ_SLEEP:    n_state = r_cur_v ? S_SINS : S_DONE;
                    default:      n_state = r_cur_v ? S_WAKE : S_DONE;
                endcase
            end
            S_SINS:   if (r_i >= r_scnt || !cmp_lt) n_state = S_SSHIFT;
            S_SSHIFT: if (r_i <= r_best) n_state = S_WAKE;
            S_WAKE: begin
                if (r_scnt != '0 && cmp_le) n_state = S_WSHIFT;
                else if (r_rcnt == '0) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_WSHIFT: if (r_i >= r_scnt) n_state = S_WAKE;
            S_SCAN:   if (r_i >= r_rcnt) n_state = S_RSHIFT;
            S_RSHIFT: if (r_i >= r_rcnt) n_state = S_PICK;
            S_PICK:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_tstat[k]  <= TS_FREE;
                r_credit[k] <= '0;
                r_prio[k]   <= '0;
            end
            r_rcnt  <= '0;
            r_scnt  <= '0;
            r_time  <= '0;
            r_cur   <= '0;
            r_cur_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            case (r_state)
                S_IDLE: if (start) begin
                    r_i    <= '0;
                    r_best <= '0;
                    r_tsk  <= r_cur;
                    case (t_req'(i_item.req_type))
                        REQ_TICK: begin
                            r_stat <= STAT_OK;
                            if (r_time != 32'hFFFF_FFFF) r_time <= r_time + 32'd1;
                        end
                        REQ_ADMIT: begin
                            if (!id_ok || (r_tstat[in_id] != TS_FREE &&
                                           r_tstat[in_id] != TS_EXITED)) begin
                                r_stat <= STAT_BADTSK;
                            end else begin
                                r_stat <= STAT_OK;
                                r_prio[in_id]   <= (i_item.priority_req == 4'd0) ?
                                                   4'd1 : i_item.priority_req;
                                r_credit[in_id] <= (i_item.priority_req == 4'd0) ?
                                                   4'd1 : i_item.priority_req;
                                r_rq[IW'(r_rcnt)] <= in_id;
                                r_rcnt <= r_rcnt + 1'b1;
                                r_tstat[in_id] <= TS_READY;
                            end
                        end
                        REQ_UNBLOCK: begin
                            if (!id_ok || r_tstat[in_id] != TS_BLOCKED) begin
                                r_stat <= STAT_BADTSK;
                            end else begin
                                r_stat <= STAT_OK;
                                r_rq[IW'(r_rcnt)] <= in_id;
                                r_rcnt <= r_rcnt + 1'b1;
                                r_tstat[in_id] <= TS_READY;
                            end
                        end
                        REQ_DISPATCH: begin
                            r_stat <= STAT_OK;
                            if (r_cur_v) begin
                                r_rq[IW'(r_rcnt)] <= r_cur;
                                r_rcnt <= r_rcnt + 1'b1;
                                r_tstat[r_cur] <= TS_READY;
                                r_cur_v <= 1'b0;
                            end
                        end
                        default: begin
                            if (!r_cur_v) begin
                                r_stat <= STAT_NOCUR;
                            end else begin
                                r_stat  <= STAT_OK;
                                r_cur_v <= 1'b0;
                                case (t_req'(i_item.req_type))
                                    REQ_YIELD: begin
                                        r_rq[IW'(r_rcnt)] <= r_cur;
                                        r_rcnt <= r_rcnt + 1'b1;
                                        r_tstat[r_cur] <= TS_READY;
                                    end
                                    REQ_EXIT:  r_tstat[r_cur] <= TS_EXITED;
                                    REQ_BLOCK: r_tstat[r_cur] <= TS_BLOCKED;
                                    default:   r_tstat[r_cur] <= TS_SLEEPING;
                                endcase
                            end
                        end
                    endcase
                end
                S_SINS: begin
                    if (r_i >= r_scnt || !cmp_lt) begin
                        r_best <= r_i;      // insert position
                        r_i    <= r_scnt;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SSHIFT: begin
                    if (r_i > r_best) begin
                        r_sq[IW'(r_i)] <= r_sq[IW'(r_i - 1'b1)];
                        r_i <= r_i - 1'b1;
                    end else begin
                        r_sq[IW'(r_best)] <= r_tsk;
                        r_scnt <= r_scnt + 1'b1;
                    end
                end
                S_WAKE: begin
                    r_i    <= CW'(1);
                    r_best <= '0;
                    if (r_scnt != '0 && cmp_le) begin
                        r_tsk <= s_head;
                        r_rq[IW'(r_rcnt)] <= s_head;
                        r_rcnt <= r_rcnt + 1'b1;
                        r_tstat[s_head] <= TS_READY;
                    end else if (r_rcnt == '0) begin
                        r_cur   <= '0;
                        r_cur_v <= 1'b0;
                    end
                end
                S_WSHIFT: begin
                    if (r_i < r_scnt) begin
                        r_sq[IW'(r_i - 1'b1)] <= s_at_i;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_scnt <= r_scnt - 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_i < r_rcnt) begin
                        if (cmp_lt) r_best <= r_i;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_tsk <= r_at_best;
                        r_i   <= r_best + 1'b1;
                    end
                end
                S_RSHIFT: begin
                    if (r_i < r_rcnt) begin
                        r_rq[IW'(r_i - 1'b1)] <= r_at_i;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_rcnt <= r_rcnt - 1'b1;
                    end
                end
                S_PICK: begin
                    r_credit[r_tsk] <= (r_credit[r_tsk] <= 4'd1) ?
                                       r_prio[r_tsk] : r_credit[r_tsk] - 4'd1;
                    r_tstat[r_tsk] <= TS_RUNNING;
                    r_cur   <= r_tsk;
                    r_cur_v <= 1'b1;
                end
                default: ;
            endcase
            // Sleep deadline is written as the insert walk starts
            if (r_state == S_IDLE && start &&
                t_req'(i_item.req_type) == REQ_SLEEP && r_cur_v) begin
                r_dl[r_cur] <= dl_sum;
            end
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        r_out.running_task  <= r_cur_v ? 3'(r_cur) : 3'd0;
        r_out.running_valid <= r_cur_v;
        r_out.status        <= r_stat;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

FILE: dv/tb_credit_priority_task_scheduler.sv
// Testbench for the credit-priority task scheduler: directed and random requests, scoreboard check.
module tb_credit_priority_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import cpts_pkg::*;

    localparam int NT = 8;
    localparam int N_RANDOM = 850;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;

    // Scheduler mirror and queue of predicted answers
    class sched_scoreboard;
        logic [31:0] now;
        t_tstate     state_of [NT];
        logic [3:0]  credit [NT];
        logic [3:0]  prio [NT];
        logic [31:0] deadline [NT];
        int          ready_q [$];
        int          sleep_q [$];
        int          cur;
        bit          cur_valid;
        t_out_word   pending [$];
        int          errors;
        int          n_checked;
        int          n_passes;
        int          n_idle;

        function new();
            now = '0;
            cur = 0;
            cur_valid = 0;
            errors = 0;
            n_checked = 0;
            n_passes = 0;
            n_idle = 0;
            for (int i = 0; i < NT; i++) begin
                state_of[i] = TS_FREE;
                credit[i] = '0;
                prio[i] = '0;
                deadline[i] = '0;
            end
        endfunction

        function void to_ready(int t);
            if (ready_q.size() < NT) begin
                ready_q.push_back(t);
                state_of[t] = TS_READY;
            end
        endfunction

        function void run_pass();
            int best;
            int t;
            n_passes++;
            // wake expired sleepers in list order
            while (sleep_q.size() > 0 && deadline[sleep_q[0]] <= now) begin
                t = sleep_q.pop_front();
                to_ready(t);
            end
            if (ready_q.size() == 0) begin
                cur_valid = 0;
                cur = 0;
                n_idle++;
                return;
            end
            best = 0;
            for (int i = 1; i < ready_q.size(); i++)
                if (credit[ready_q[i]] > credit[ready_q[best]]) best = i;
            t = ready_q[best];
            ready_q.delete(best);
            if (credit[t] <= 1) credit[t] = prio[t];
            else credit[t] = credit[t] - 4'd1;
            state_of[t] = TS_RUNNING;
            cur = t;
            cur_valid = 1;
        endfunction

        // note an accepted request word
        function void note_request(t_in_word w);
            logic [1:0]  st;
            logic [32:0] dl;
            logic [3:0]  p;
            int          pos;
            t_out_word   r;
            st = STAT_OK;
            case (t_req'(w.req_type))
                REQ_TICK: if (now != TIME_SAT) now = now + 32'd1;
                REQ_ADMIT: begin
                    if (state_of[w.task_id] != TS_FREE && state_of[w.task_id] != TS_EXITED) begin
                        st = STAT_BADTSK;
                    end else begin
                        p = (w.priority_req == 0) ? 4'd1 : w.priority_req;
                        prio[w.task_id] = p;
                        credit[w.task_id] = p;
                        to_ready(w.task_id);
                    end
                end
                REQ_UNBLOCK: begin
                    if (state_of[w.task_id] != TS_BLOCKED) st = STAT_BADTSK;
                    else to_ready(w.task_id);
                end
                REQ_DISPATCH: begin
                    if (cur_valid) begin
                        to_ready(cur);
                        cur_valid = 0;
                    end
                    run_pass();
                end
                default: begin
                    if (!cur_valid) begin
                        st = STAT_NOCUR;
                    end else begin
                        case (t_req'(w.req_type))
                            REQ_YIELD: to_ready(cur);
                            REQ_SLEEP: begin
                                dl = {1'b0, now} + 33'(w.sleep_time);
                                deadline[cur] = dl[32] ? TIME_SAT : dl[31:0];
                                if (sleep_q.size() < NT) begin
                                    pos = 0;
                                    while (pos < sleep_q.size()
                                           && deadline[sleep_q[pos]] < deadline[cur])
                                        pos++;
                                    sleep_q.insert(pos, cur);
                                    state_of[cur] = TS_SLEEPING;
                                end
                            end
                            REQ_EXIT: state_of[cur] = TS_EXITED;
                            default: state_of[cur] = TS_BLOCKED;
                        endcase
                        cur_valid = 0;
                        run_pass();
                    end
                end
            endcase
            r.running_task = cur_valid ? cur[2:0] : 3'd0;
            r.running_valid = cur_valid;
            r.status = st;
            pending.push_back(r);
        endfunction

        // compare one result word with the oldest prediction
        function void check_result(t_out_word got);
            t_out_word e;
            if (pending.size() == 0) begin
                $error("unexpected result word %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.running_task !== e.running_task) begin
                $error("running_task expected %0d actual %0d", e.running_task, got.running_task);
                errors++;
            end
            if (got.running_valid !== e.running_valid) begin
                $error("running_valid expected %0d actual %0d",
                       e.running_valid, got.running_valid);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_item;
    logic      busy;
    logic      o_done;
    t_out_word o_result;

    sched_scoreboard sb;
    int idle_cycles;

    credit_priority_task_scheduler #(.NUM_TASKS(NT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_done(o_done), .o_result(o_result)
    );

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // result monitor and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_result);
            if (o_done || (start && !busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("credit_priority_task_scheduler: mismatch");
                $finish;
            end
        end
    end

    // send one request word after a random gap; start stays up after the
    // accepting edge, where busy already blocks a second accept
    task automatic send_req(t_req rq, int id, int pr, int stime);
        t_in_word w;
        int gap;
        w.req_type = rq;
        w.task_id = id[2:0];
        w.priority_req = pr[3:0];
        w.sleep_time = stime[19:0];
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            i_item <= t_in_word'(30'($urandom));
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        sb.note_request(w);
    endtask

    task automatic send_rand();
        int k;
        int st;
        k = $urandom_range(0, 99);
        st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(0, 12);
        if (k < 20) send_req(REQ_TICK, $urandom, $urandom, $urandom);
        else if (k < 32) send_req(REQ_ADMIT, $urandom_range(0, 7), $urandom_range(0, 15), $urandom);
        else if (k < 47) send_req(REQ_YIELD, $urandom, $urandom, $urandom);
        else if (k < 60) send_req(REQ_SLEEP, $urandom, $urandom, st);
        else if (k < 66) send_req(REQ_EXIT, $urandom, $urandom, $urandom);
        else if (k < 73) send_req(REQ_BLOCK, $urandom, $urandom, $urandom);
        else if (k < 82) send_req(REQ_UNBLOCK, $urandom_range(0, 7), $urandom, $urandom);
        else send_req(REQ_DISPATCH, $urandom, $urandom, $urandom);
    endtask

    initial begin
        sb = new();
        idle_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-scheduler cases, zero priority, extremes, wrong states
        send_req(REQ_YIELD, 0, 0, 0);
        send_req(REQ_DISPATCH, 0, 0, 0);
        send_req(REQ_UNBLOCK, 7, 0, 0);
        send_req(REQ_ADMIT, 0, 0, 0);
        send_req(REQ_ADMIT, 7, 15, 20'hFFFFF);
        send_req(REQ_ADMIT, 7, 3, 0);
        send_req(REQ_ADMIT, 3, 1, 0);
        send_req(REQ_DISPATCH, 0, 0, 0);
        send_req(REQ_DISPATCH, 0, 0, 0);
        send_req(REQ_YIELD, 0, 0, 0);
        send_req(REQ_SLEEP, 0, 0, 20'hFFFFF);
        send_req(REQ_SLEEP, 0, 0, 2);
        send_req(REQ_SLEEP, 0, 0, 2);
        send_req(REQ_TICK, 0, 0, 0);
        send_req(REQ_TICK, 0, 0, 0);
        send_req(REQ_DISPATCH, 0, 0, 0);
        send_req(REQ_BLOCK, 0, 0, 0);
        send_req(REQ_UNBLOCK, 3, 0, 0);
        send_req(REQ_UNBLOCK, 0, 0, 0);
        send_req(REQ_EXIT, 0, 0, 0);
        send_req(REQ_ADMIT, 0, 9, 0);
        send_req(REQ_SLEEP, 0, 0, 0);
        send_req(REQ_EXIT, 0, 0, 0);

        for (int n = 0; n < N_RANDOM; n++) send_rand();
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d checked words, %0d scheduling passes, %0d idle outcomes",
                 sb.n_checked, sb.n_passes, sb.n_idle);
        if (sb.errors == 0) $display("credit_priority_task_scheduler: match");
        else $display("credit_priority_task_scheduler: mismatch");
        $finish;
    end
endmodule
